// ===== src/i2cm_pkg.sv =====
package i2cm_pkg;

  // Width of the bus delay counter.
  localparam int unsigned WaitW = 16;

  // Widths of the delay product: microseconds times ticks per microsecond.
  localparam int unsigned MicrosW = 3;
  localparam int unsigned TicksW  = 10;
  localparam int unsigned ProdW   = MicrosW + TicksW;
  localparam int unsigned CmpW    = (WaitW > ProdW) ? WaitW : ProdW;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 10;

  localparam logic [9:0] AckTimeoutReset = 10'd250;
  localparam logic [9:0] UsTicksReset    = 10'd1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_US_TICKS    = 1'b0,
    CFG_ACK_TIMEOUT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_START    = 3'd1,
    KIND_STOP     = 3'd2,
    KIND_WRITE    = 3'd3,
    KIND_READ     = 3'd4,
    KIND_WAIT_ACK = 3'd5
  } kind_e;

  typedef enum logic [4:0] {
    STEP_IDLE   = 5'd0,
    STEP_ST_A   = 5'd1,
    STEP_ST_B   = 5'd2,
    STEP_ST_C   = 5'd3,
    STEP_SP_A   = 5'd4,
    STEP_SP_B   = 5'd5,
    STEP_SP_C   = 5'd6,
    STEP_SP_D   = 5'd7,
    STEP_WA_A   = 5'd8,
    STEP_WA_B   = 5'd9,
    STEP_WA_C   = 5'd10,
    STEP_TX_BIT = 5'd11,
    STEP_TX_HI  = 5'd12,
    STEP_TX_LO  = 5'd13,
    STEP_TX_END = 5'd14,
    STEP_RX_LO  = 5'd15,
    STEP_RX_HI  = 5'd16,
    STEP_AK_A   = 5'd17,
    STEP_AK_B   = 5'd18,
    STEP_AK_C   = 5'd19
  } step_e;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_line;
  } in_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_ok;
  } out_item_t;

  typedef struct packed {
    logic [TicksW-1:0] us_ticks;
    logic [9:0]        ack_timeout;
  } cfg_t;

  typedef struct packed {
    step_e             step;
    logic [WaitW-1:0]  wait_count;
    logic [3:0]        bit_count;
    logic [7:0]        shifter;
    logic [9:0]        poll_count;
    logic              ack_choice;
    logic              scl_level;
    logic              sda_level;
    logic              sda_enable;
    logic [7:0]        received;
    logic              ack_result;
  } seq_state_t;

  // Delay of a given number of microseconds, saturated at the counter's all-ones value.
  function automatic logic [WaitW-1:0] delay_ticks(input logic [MicrosW-1:0] micros,
                                                   input logic [TicksW-1:0] us_ticks);
    logic [ProdW-1:0] prod;
    logic [CmpW-1:0]  ext;
    logic [CmpW-1:0]  lim;
    prod = ProdW'(micros) * ProdW'(us_ticks);
    ext  = CmpW'(prod);
    lim  = CmpW'({WaitW{1'b1}});
    return (ext > lim) ? WaitW'(lim) : WaitW'(ext);
  endfunction

endpackage

// ===== src/i2cm_cfg.sv =====
module i2cm_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [i2cm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [i2cm_pkg::CfgDataW-1:0]  cfg_data_i,
  output i2cm_pkg::cfg_t                 cfg_o
);
  import i2cm_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.us_ticks    <= UsTicksReset;
      cfg_q.ack_timeout <= AckTimeoutReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_US_TICKS:    cfg_q.us_ticks    <= TicksW'(cfg_data_i);
        CFG_ACK_TIMEOUT: cfg_q.ack_timeout <= 10'(cfg_data_i);
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/i2cm_seq.sv =====
module i2cm_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  i2cm_pkg::in_item_t  item_i,
  input  i2cm_pkg::cfg_t      cfg_i,
  output i2cm_pkg::out_item_t result_o
);
  import i2cm_pkg::*;

  seq_state_t state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.step       <= STEP_IDLE;
      state_q.wait_count <= '0;
      state_q.bit_count  <= '0;
      state_q.shifter    <= '0;
      state_q.poll_count <= '0;
      state_q.ack_choice <= 1'b0;
      state_q.scl_level  <= 1'b1;
      state_q.sda_level  <= 1'b1;
      state_q.sda_enable <= 1'b1;
      state_q.received   <= '0;
      state_q.ack_result <= 1'b0;
    end else if (en_i) begin
      state_q <= state_d;
    end
  end

  always_comb begin
    seq_state_t s;
    logic       act;
    logic       done;
    s    = state_q;
    act  = 1'b0;
    done = 1'b0;

    // An idle sequencer takes a command and runs its first phase on the same tick.
    if (s.step == STEP_IDLE) begin
      act = 1'b1;
      case (kind_e'(item_i.kind))
        KIND_START: s.step = STEP_ST_A;
        KIND_STOP:  s.step = STEP_SP_A;
        KIND_WRITE: begin
          s.sda_enable = 1'b1;
          s.scl_level  = 1'b0;
          s.shifter    = item_i.tx_byte;
          s.bit_count  = '0;
          s.step       = STEP_TX_BIT;
        end
        KIND_READ: begin
          s.sda_enable = 1'b0;
          s.shifter    = '0;
          s.bit_count  = '0;
          s.ack_choice = item_i.send_ack;
          s.step       = STEP_RX_LO;
        end
        KIND_WAIT_ACK: begin
          s.poll_count = '0;
          s.step       = STEP_WA_A;
        end
        default: act = 1'b0;
      endcase
    end else if (s.wait_count != '0) begin
      s.wait_count = s.wait_count - 1'b1;
    end else begin
      act = 1'b1;
    end

    if (act) begin
      case (s.step)
        STEP_ST_A: begin
          s.sda_enable = 1'b1;
          s.sda_level  = 1'b1;
          s.scl_level  = 1'b1;
          s.wait_count = delay_ticks(3'd5, cfg_i.us_ticks);
          s.step       = STEP_ST_B;
        end
        STEP_ST_B: begin
          s.sda_level  = 1'b0;
          s.wait_count = delay_ticks(3'd6, cfg_i.us_ticks);
          s.step       = STEP_ST_C;
        end
        STEP_ST_C: begin
          s.scl_level = 1'b0;
          s.step      = STEP_IDLE;
          done        = 1'b1;
        end
        STEP_SP_A: begin
          s.sda_enable = 1'b1;
          s.scl_level  = 1'b0;
          s.sda_level  = 1'b0;
          s.wait_count = '0;
          s.step       = STEP_SP_B;
        end
        STEP_SP_B: begin
          s.scl_level  = 1'b1;
          s.wait_count = delay_ticks(3'd6, cfg_i.us_ticks);
          s.step       = STEP_SP_C;
        end
        STEP_SP_C: begin
          s.sda_level  = 1'b1;
          s.wait_count = delay_ticks(3'd6, cfg_i.us_ticks);
          s.step       = STEP_SP_D;
        end
        STEP_SP_D: begin
          s.step = STEP_IDLE;
          done   = 1'b1;
        end
        STEP_WA_A: begin
          s.sda_level  = 1'b1;
          s.wait_count = delay_ticks(3'd1, cfg_i.us_ticks);
          s.step       = STEP_WA_B;
        end
        STEP_WA_B: begin
          s.sda_enable = 1'b0;
          s.scl_level  = 1'b1;
          s.wait_count = delay_ticks(3'd1, cfg_i.us_ticks);
          s.step       = STEP_WA_C;
        end
        STEP_WA_C: begin
          if (!item_i.sda_line) begin
            s.scl_level  = 1'b0;
            s.ack_result = 1'b1;
            s.step       = STEP_IDLE;
            done         = 1'b1;
          end else if (s.poll_count >= cfg_i.ack_timeout) begin
            // Timed out: report failure and release the bus with a stop.
            s.ack_result = 1'b0;
            s.sda_enable = 1'b1;
            s.scl_level  = 1'b0;
            s.sda_level  = 1'b0;
            s.wait_count = '0;
            s.step       = STEP_SP_B;
          end else begin
            s.poll_count = s.poll_count + 1'b1;
          end
        end
        STEP_TX_BIT: begin
          s.sda_level  = s.shifter[7];
          s.shifter    = {s.shifter[6:0], 1'b0};
          s.wait_count = delay_ticks(3'd2, cfg_i.us_ticks);
          s.step       = STEP_TX_HI;
        end
        STEP_TX_HI: begin
          s.scl_level  = 1'b1;
          s.wait_count = delay_ticks(3'd2, cfg_i.us_ticks);
          s.step       = STEP_TX_LO;
        end
        STEP_TX_LO: begin
          s.scl_level  = 1'b0;
          s.wait_count = delay_ticks(3'd2, cfg_i.us_ticks);
          s.bit_count  = s.bit_count + 1'b1;
          s.step       = (s.bit_count >= 4'd8) ? STEP_TX_END : STEP_TX_BIT;
        end
        STEP_TX_END: begin
          s.step = STEP_IDLE;
          done   = 1'b1;
        end
        STEP_RX_LO: begin
          s.scl_level  = 1'b0;
          s.wait_count = delay_ticks(3'd2, cfg_i.us_ticks);
          s.step       = STEP_RX_HI;
        end
        STEP_RX_HI: begin
          s.scl_level  = 1'b1;
          s.shifter    = {s.shifter[6:0], item_i.sda_line};
          s.wait_count = delay_ticks(3'd1, cfg_i.us_ticks);
          s.bit_count  = s.bit_count + 1'b1;
          s.step       = (s.bit_count >= 4'd8) ? STEP_AK_A : STEP_RX_LO;
        end
        STEP_AK_A: begin
          s.received   = s.shifter;
          s.scl_level  = 1'b0;
          s.sda_enable = 1'b1;
          s.sda_level  = ~s.ack_choice;
          s.wait_count = delay_ticks(3'd2, cfg_i.us_ticks);
          s.step       = STEP_AK_B;
        end
        STEP_AK_B: begin
          s.scl_level  = 1'b1;
          s.wait_count = delay_ticks(3'd5, cfg_i.us_ticks);
          s.step       = STEP_AK_C;
        end
        STEP_AK_C: begin
          s.scl_level = 1'b0;
          s.step      = STEP_IDLE;
          done        = 1'b1;
        end
        default: s.step = STEP_IDLE;
      endcase
    end

    state_d            = s;
    result_o.scl       = s.scl_level;
    result_o.sda_out   = s.sda_level;
    result_o.sda_drive = s.sda_enable;
    result_o.busy_res  = (s.step != STEP_IDLE);
    result_o.done_res  = done;
    result_o.rx_byte   = s.received;
    result_o.ack_ok    = s.ack_result;
  end

endmodule

// ===== src/i2c_master_bit_engine.sv =====
// I2C master pin sequencer. Every input transaction is one bus tick: it may carry a
// command (start, stop, write byte, read byte, wait for acknowledge) and always carries
// the sampled SDA level, and it produces exactly one output transaction with the SCL
// level, the SDA level and drive enable, busy and done flags, the last received byte and
// the last acknowledge result. Bus delays of n microseconds last n times us_ticks ticks
// (register 0); the acknowledge wait gives up after ack_timeout high polls (register 1),
// then issues a stop and reports ack_ok low. Commands that arrive while busy are dropped.
// The block takes one transaction per clock cycle as long as the output side does not stall:
// a transaction is captured in an input register, and the sequencer step logic runs on it
// and writes the result register once that register has room for the result.
module i2c_master_bit_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  i2cm_pkg::in_item_t             in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output i2cm_pkg::out_item_t            out_item_o,
  input  logic                           cfg_we_i,
  input  logic [i2cm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [i2cm_pkg::CfgDataW-1:0]  cfg_data_i
);
  import i2cm_pkg::*;

  cfg_t      cfg;
  in_item_t  in_item_q;
  logic      in_valid_q;
  out_item_t out_item_q;
  logic      out_valid_q;
  out_item_t result;
  logic      out_free;
  logic      advance;
  logic      in_take;

  // The result register can take a new result when it is empty or being drained.
  assign out_free   = ~out_valid_q | ~out_stall_i;
  // The held transaction moves through the sequencer when there is room for its result.
  assign advance    = in_valid_q & out_free;
  assign in_stall_o = in_valid_q & ~out_free;
  assign in_take    = in_valid_i & ~in_stall_o;

  i2cm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  i2cm_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (~out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
